>>> hw/rtl/dgf_pkg.sv
// types, constants and arithmetic helpers for the diffusion geometric factor pipeline
package dgf_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int NUM_W     = DW + FB;
    localparam int SQ_STEPS  = NUM_W / 2;
    localparam int SQ_REM_W  = SQ_STEPS + 3;
    localparam int DIV_STEPS = NUM_W;
    localparam int N_OPS     = 11;
    localparam int N_PROD1   = 28;
    localparam int N_PROD4   = 23;
    localparam int N_ADJ     = 9;
    localparam int N_ENTRY   = 6;
    localparam int N_CARRY   = 3;

    localparam logic [1:0] MODE_PLANAR  = 2'd0;
    localparam logic [1:0] MODE_VOLUME  = 2'd1;
    localparam logic [1:0] MODE_SURFACE = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COEFF = 1'b1;

    typedef logic signed [DW-1:0]   q_t;
    typedef logic signed [2*DW-1:0] prod_t;

    localparam q_t Q_MAX     = {1'b0, {(DW-1){1'b1}}};
    localparam q_t Q_MIN     = {1'b1, {(DW-1){1'b0}}};
    localparam q_t COEFF_ONE = q_t'(1) <<< FB;

    // values that ride along the adjugate stages
    typedef struct packed {
        q_t wc;
        q_t sa;
        q_t sb;
        q_t sc;
        q_t e;
        q_t g;
        q_t fm;
        q_t det0;
    } carry_t;

    typedef struct packed {
        logic                         sing;
        logic                         negb;
        logic                         use_root;
        logic                         qneg;
        logic [DW-1:0]                wmag;
        logic [DW-1:0]                dmag;
        q_t                           area;
        logic [N_ENTRY-1:0][DW-1:0]   x;
    } geo_t;

    typedef struct packed {
        geo_t                 g;
        logic [NUM_W-1:0]     rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_STEPS-1:0]  root;
    } sq_t;

    typedef struct packed {
        geo_t              g;
        logic [DW-1:0]     dv;
        logic [NUM_W-1:0]  num;
        logic [DW-1:0]     rem;
        logic [NUM_W-1:0]  quo;
    } dv_t;

    // product shifted down with truncation toward zero, then saturated
    function automatic q_t fixq(prod_t p);
        prod_t                   t;
        logic [2*DW-FB-1:0]      s;
        logic [2*DW-FB-DW:0]     top;
        t = p + (p[2*DW-1] ? prod_t'((64'd1 << FB) - 64'd1) : prod_t'(0));
        s = t[2*DW-1:FB];
        top = s[2*DW-FB-1:DW-1];
        if ((&top) || !(|top))
            return s[DW-1:0];
        else
            return s[2*DW-FB-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic q_t addsat(q_t a, q_t b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? Q_MIN : Q_MAX;
        return s[DW-1:0];
    endfunction

    function automatic q_t subsat(q_t a, q_t b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? Q_MIN : Q_MAX;
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] magq(q_t a);
        return a[DW-1] ? (~a + 1'b1) : a;
    endfunction

    // one result bit of the integer square root
    function automatic sq_t sq_step(sq_t s);
        sq_t                 o;
        logic [SQ_REM_W-1:0] r2;
        logic [SQ_REM_W-1:0] t;
        o = s;
        r2 = {s.rem[SQ_REM_W-3:0], s.rad[NUM_W-1 -: 2]};
        t = {1'b0, s.root, 2'b01};
        if (r2 >= t)
        begin
            o.rem  = r2 - t;
            o.root = {s.root[SQ_STEPS-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {s.root[SQ_STEPS-2:0], 1'b0};
        end
        o.rad = s.rad << 2;
        return o;
    endfunction

    // one quotient bit of the restoring divider
    function automatic dv_t dv_step(dv_t s);
        dv_t         o;
        logic [DW:0] cand;
        o = s;
        cand = {s.rem, s.num[NUM_W-1]};
        if (cand >= {1'b0, s.dv})
        begin
            cand  = cand - {1'b0, s.dv};
            o.quo = {s.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            o.quo = {s.quo[NUM_W-2:0], 1'b0};
        end
        o.rem = cand[DW-1:0];
        o.num = s.num << 1;
        return o;
    endfunction

endpackage

>>> hw/rtl/diffusion_geometric_factor.sv
// diffusion geometric factor: fully pipelined metric tensor over jacobian, root and divide
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | quadrature point (jacobian, weight)
//  m_*     | out | m_tvalid / m_tready | six factor entries, singular in tuser
//  cfg_*   | in  | cfg_valid/cfg_ready | register index and write data
//
// one point enters every cycle while the pipeline is not held (see below)
// the pipeline is made of 6 product and adjugate stages, a 24 stage square root,
// a 48 stage divider (one quotient bit per stage) and 3 scaling stages plus the output register
// all stages advance together; they hold only while a valid result waits at the
// output and another one sits in the last stage, so bubbles are squeezed out
// reset clears the valid bits and sets mode 0, coeff 1.0
module diffusion_geometric_factor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // jac_11, jac_21, jac_31, jac_12, jac_22, jac_32, jac_13, jac_23, jac_33, weight, pad
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // factor_a, factor_b, factor_c, factor_d, factor_e, factor_f
    output logic [191:0] m_tdata,
    // singular
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import dgf_pkg::*;

    localparam int OPA [N_PROD1] = '{4, 7, 5, 3, 3, 4, 2, 1, 0, 6, 1, 0, 1, 2,
                                     2, 0, 0, 3, 0, 1, 2, 3, 4, 5, 0, 1, 2, 9};
    localparam int OPB [N_PROD1] = '{8, 5, 6, 8, 7, 6, 7, 8, 8, 2, 6, 7, 5, 4,
                                     3, 5, 4, 1, 0, 1, 2, 3, 4, 5, 3, 4, 5, 10};
    localparam int D_R1 [N_ENTRY] = '{0, 0, 0, 1, 1, 2};
    localparam int D_R2 [N_ENTRY] = '{0, 1, 2, 1, 2, 2};

    logic [1:0] mode_reg;
    q_t         coeff_reg;

    logic en;
    logic out_valid_reg;

    q_t     ops [N_OPS];

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    prod_t  p1_reg [N_PROD1];
    q_t     q2_reg [N_PROD1];
    q_t     j1_reg [N_CARRY];
    q_t     j2_reg [N_CARRY];
    q_t     j3_reg [N_CARRY];
    q_t     a3_reg [N_ADJ];
    carry_t c3_next, c3_reg, c4_reg, c5_reg;
    q_t     a3_next [N_ADJ];
    prod_t  p4_reg [N_PROD4];
    q_t     q5_reg [N_PROD4];
    geo_t   geo6_next, geo6_reg;

    logic [SQ_STEPS-1:0]  sq_v_reg;
    sq_t                  sq_in [SQ_STEPS];
    sq_t                  sq_reg [SQ_STEPS];
    logic [DIV_STEPS-1:0] dv_v_reg;
    dv_t                  dv_in [DIV_STEPS];
    dv_t                  dv_reg [DIV_STEPS];

    logic   vc_reg, vm1_reg, vm2_reg;
    q_t     c_next, c_reg;
    geo_t   gc_reg, gm1_reg, gm2_reg;
    prod_t  pm1_reg [N_ENTRY];
    q_t     fm2_reg [N_ENTRY];
    q_t     out_next [N_ENTRY];
    q_t     out_reg  [N_ENTRY];
    logic   out_sing_reg;

    assign en        = m_tready | ~out_valid_reg | ~vm2_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLANAR;
            coeff_reg <= COEFF_ONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_COEFF: coeff_reg <= cfg_data;
                default:   coeff_reg <= coeff_reg;
            endcase
        end
    end

    // operand vector: nine jacobian entries, weight, coefficient
    always_comb
    begin
        for (int i = 0; i < N_ADJ; i++)
            ops[i] = s_tdata[i*DW +: DW];
        ops[9]  = {1'b0, s_tdata[N_ADJ*DW +: DW-1]};
        ops[10] = coeff_reg;
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            sq_v_reg <= '0;
            dv_v_reg <= '0;
            vc_reg   <= 1'b0;
            vm1_reg  <= 1'b0;
            vm2_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= s_tvalid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            sq_v_reg <= {sq_v_reg[SQ_STEPS-2:0], v6_reg};
            dv_v_reg <= {dv_v_reg[DIV_STEPS-2:0], sq_v_reg[SQ_STEPS-1]};
            vc_reg   <= dv_v_reg[DIV_STEPS-1];
            vm1_reg  <= vc_reg;
            vm2_reg  <= vm1_reg;
        end
    end

    // adjugate entries, 2d sums and fundamental form
    always_comb
    begin
        for (int i = 0; i < N_ADJ; i++)
            a3_next[i] = subsat(q2_reg[2*i], q2_reg[2*i+1]);
        c3_next.wc   = q2_reg[27];
        c3_next.sa   = addsat(q2_reg[21], q2_reg[22]);
        c3_next.sb   = addsat(q2_reg[24], q2_reg[25]);
        c3_next.sc   = addsat(q2_reg[18], q2_reg[19]);
        c3_next.e    = addsat(addsat(q2_reg[18], q2_reg[19]), q2_reg[20]);
        c3_next.g    = addsat(addsat(q2_reg[21], q2_reg[22]), q2_reg[23]);
        c3_next.fm   = addsat(addsat(q2_reg[24], q2_reg[25]), q2_reg[26]);
        c3_next.det0 = subsat(q2_reg[16], q2_reg[17]);
    end

    // determinant, dot products and area per mode
    always_comb
    begin
        q_t det1;
        q_t area;
        q_t dots [N_ENTRY];
        for (int d = 0; d < N_ENTRY; d++)
            dots[d] = addsat(addsat(q5_reg[3*d], q5_reg[3*d+1]), q5_reg[3*d+2]);
        det1 = addsat(addsat(q5_reg[18], q5_reg[19]), q5_reg[20]);
        area = subsat(q5_reg[21], q5_reg[22]);
        geo6_next      = '0;
        geo6_next.wmag = magq(c5_reg.wc);
        geo6_next.area = area;
        unique case (mode_reg)
            MODE_PLANAR:
            begin
                geo6_next.sing = (c5_reg.det0 == '0);
                geo6_next.negb = 1'b1;
                geo6_next.qneg = c5_reg.wc[DW-1] ^ c5_reg.det0[DW-1];
                geo6_next.dmag = magq(c5_reg.det0);
                geo6_next.x[0] = c5_reg.sa;
                geo6_next.x[1] = c5_reg.sb;
                geo6_next.x[2] = c5_reg.sc;
            end
            MODE_VOLUME:
            begin
                geo6_next.sing = (det1 == '0);
                geo6_next.qneg = c5_reg.wc[DW-1] ^ det1[DW-1];
                geo6_next.dmag = magq(det1);
                for (int d = 0; d < N_ENTRY; d++)
                    geo6_next.x[d] = dots[d];
            end
            MODE_SURFACE:
            begin
                geo6_next.sing     = area[DW-1] || (area == '0);
                geo6_next.negb     = 1'b1;
                geo6_next.use_root = 1'b1;
                geo6_next.qneg     = c5_reg.wc[DW-1];
                geo6_next.x[0]     = c5_reg.g;
                geo6_next.x[1]     = c5_reg.fm;
                geo6_next.x[2]     = c5_reg.e;
            end
            default:
            begin
                geo6_next.sing = 1'b1;
            end
        endcase
    end

    // chain inputs of the root and divider stages
    always_comb
    begin
        sq_in[0].g    = geo6_reg;
        sq_in[0].rem  = '0;
        sq_in[0].root = '0;
        sq_in[0].rad  = (geo6_reg.use_root && !geo6_reg.sing) ?
                        {geo6_reg.area, {FB{1'b0}}} : '0;
        for (int i = 1; i < SQ_STEPS; i++)
            sq_in[i] = sq_reg[i-1];
        dv_in[0].g   = sq_reg[SQ_STEPS-1].g;
        dv_in[0].dv  = sq_reg[SQ_STEPS-1].g.use_root ?
                       {{(DW-SQ_STEPS){1'b0}}, sq_reg[SQ_STEPS-1].root} :
                       sq_reg[SQ_STEPS-1].g.dmag;
        dv_in[0].num = {sq_reg[SQ_STEPS-1].g.wmag, {FB{1'b0}}};
        dv_in[0].rem = '0;
        dv_in[0].quo = '0;
        for (int i = 1; i < DIV_STEPS; i++)
            dv_in[i] = dv_reg[i-1];
    end

    // signed, saturated quotient
    always_comb
    begin
        logic [NUM_W-1:0] lim;
        logic [DW-1:0]    qm;
        lim = dv_reg[DIV_STEPS-1].g.qneg ? NUM_W'({1'b1, {(DW-1){1'b0}}}) :
                                            NUM_W'({1'b0, {(DW-1){1'b1}}});
        qm  = (dv_reg[DIV_STEPS-1].quo > lim) ? lim[DW-1:0] :
                                                dv_reg[DIV_STEPS-1].quo[DW-1:0];
        c_next = dv_reg[DIV_STEPS-1].g.qneg ? q_t'(~qm + 1'b1) : q_t'(qm);
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_PROD1; k++)
                p1_reg[k] <= prod_t'(ops[OPA[k]]) * prod_t'(ops[OPB[k]]);
            for (int k = 0; k < N_CARRY; k++)
            begin
                j1_reg[k] <= ops[k];
                j2_reg[k] <= j1_reg[k];
                j3_reg[k] <= j2_reg[k];
            end
            for (int k = 0; k < N_PROD1; k++)
                q2_reg[k] <= fixq(p1_reg[k]);
            for (int k = 0; k < N_ADJ; k++)
                a3_reg[k] <= a3_next[k];
            c3_reg <= c3_next;
            for (int d = 0; d < N_ENTRY; d++)
                for (int k = 0; k < 3; k++)
                    p4_reg[3*d+k] <= prod_t'(a3_reg[D_R1[d]*3+k]) *
                                     prod_t'(a3_reg[D_R2[d]*3+k]);
            for (int k = 0; k < N_CARRY; k++)
                p4_reg[18+k] <= prod_t'(j3_reg[k]) * prod_t'(a3_reg[k]);
            p4_reg[21] <= prod_t'(c3_reg.e) * prod_t'(c3_reg.g);
            p4_reg[22] <= prod_t'(c3_reg.fm) * prod_t'(c3_reg.fm);
            c4_reg <= c3_reg;
            for (int k = 0; k < N_PROD4; k++)
                q5_reg[k] <= fixq(p4_reg[k]);
            c5_reg   <= c4_reg;
            geo6_reg <= geo6_next;
            for (int i = 0; i < SQ_STEPS; i++)
                sq_reg[i] <= sq_step(sq_in[i]);
            for (int i = 0; i < DIV_STEPS; i++)
                dv_reg[i] <= dv_step(dv_in[i]);
            c_reg  <= c_next;
            gc_reg <= dv_reg[DIV_STEPS-1].g;
            for (int k = 0; k < N_ENTRY; k++)
                pm1_reg[k] <= prod_t'(c_reg) * prod_t'(q_t'(gc_reg.x[k]));
            gm1_reg <= gc_reg;
            for (int k = 0; k < N_ENTRY; k++)
                fm2_reg[k] <= fixq(pm1_reg[k]);
            gm2_reg <= gm1_reg;
        end
    end

    // entry 1,2 is negated in the 2d modes; singular points give zeros
    always_comb
    begin
        for (int k = 0; k < N_ENTRY; k++)
        begin
            if (gm2_reg.sing)
                out_next[k] = '0;
            else if (k == 1 && gm2_reg.negb)
                out_next[k] = subsat('0, fm2_reg[k]);
            else
                out_next[k] = fm2_reg[k];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (m_tready || !out_valid_reg)
            out_valid_reg <= vm2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            for (int k = 0; k < N_ENTRY; k++)
                out_reg[k] <= out_next[k];
            out_sing_reg <= gm2_reg.sing;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_sing_reg;
    always_comb
    begin
        for (int k = 0; k < N_ENTRY; k++)
            m_tdata[k*DW +: DW] = out_reg[k];
    end

endmodule

>>> dv/tb_diffusion_geometric_factor.sv
// testbench for the diffusion geometric factor pipeline with a built-in fixed-point predictor
`timescale 1ns / 100ps

module tb_diffusion_geometric_factor;
    import dgf_pkg::*;

    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam int         LATENCY    = 82;
    localparam longint     CYCLE_CAP  = 400000;
    localparam longint     SAT_HI     = 64'sd2147483647;
    localparam longint     SAT_LO     = -64'sd2147483648;

    typedef struct {
        q_t          jac [9];   // 11, 21, 31, 12, 22, 32, 13, 23, 33
        logic [30:0] weight;
    } point_t;

    typedef struct {
        q_t   f [6];
        logic sing;
    } factor_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    logic [1:0]   cur_mode;
    q_t           cur_coeff;
    factor_t      factor_q [$];
    int           err_count;
    longint       cycles;
    bit           burst;

    diffusion_geometric_factor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[diffusion_geometric_factor] ERROR");
            $finish;
        end
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint sat32(longint x);
        if (x > SAT_HI)
            return SAT_HI;
        if (x < SAT_LO)
            return SAT_LO;
        return x;
    endfunction

    // exact product, truncated toward zero
    function automatic longint qmul(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >>> FB;
        return sat32((p < 0) ? -m : m);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        if (d == 0)
            return 0;
        return sat32((n <<< FB) / d);
    endfunction

    function automatic longint qroot(longint a);
        longint unsigned rad;
        longint unsigned r;
        longint unsigned t;
        rad = longint'(a) << FB;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= rad)
                r = t;
        end
        return sat32(longint'(r));
    endfunction

    function automatic longint qcross(longint a, longint b, longint c, longint d);
        return sat32(qmul(a, b) - qmul(c, d));
    endfunction

    function automatic longint qdot(longint a1, longint b1, longint a2, longint b2,
                                    longint a3, longint b3);
        return sat32(sat32(qmul(a1, b1) + qmul(a2, b2)) + qmul(a3, b3));
    endfunction

    function automatic factor_t predict_factor(point_t p);
        factor_t r;
        longint  j11, j21, j31, j12, j22, j32, j13, j23, j33;
        longint  wc, det, c, e, g, fm, area, alpha;
        longint  a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint  f [6];
        j11 = p.jac[0]; j21 = p.jac[1]; j31 = p.jac[2];
        j12 = p.jac[3]; j22 = p.jac[4]; j32 = p.jac[5];
        j13 = p.jac[6]; j23 = p.jac[7]; j33 = p.jac[8];
        wc = qmul(longint'(p.weight), longint'(cur_coeff));
        foreach (f[k])
            f[k] = 0;
        r.sing = 1'b0;
        case (cur_mode)
            MODE_PLANAR:
            begin
                det = qcross(j11, j22, j21, j12);
                if (det == 0)
                    r.sing = 1'b1;
                else
                begin
                    c = qdiv(wc, det);
                    f[0] = qmul(c, sat32(qmul(j12, j12) + qmul(j22, j22)));
                    f[1] = sat32(-qmul(c, sat32(qmul(j12, j11) + qmul(j22, j21))));
                    f[2] = qmul(c, sat32(qmul(j11, j11) + qmul(j21, j21)));
                end
            end
            MODE_VOLUME:
            begin
                a11 = qcross(j22, j33, j23, j32);
                a12 = qcross(j32, j13, j12, j33);
                a13 = qcross(j12, j23, j22, j13);
                a21 = qcross(j31, j23, j21, j33);
                a22 = qcross(j11, j33, j13, j31);
                a23 = qcross(j21, j13, j11, j23);
                a31 = qcross(j21, j32, j31, j22);
                a32 = qcross(j31, j12, j11, j32);
                a33 = qcross(j11, j22, j12, j21);
                det = qdot(j11, a11, j21, a12, j31, a13);
                if (det == 0)
                    r.sing = 1'b1;
                else
                begin
                    c = qdiv(wc, det);
                    f[0] = qmul(c, qdot(a11, a11, a12, a12, a13, a13));
                    f[1] = qmul(c, qdot(a11, a21, a12, a22, a13, a23));
                    f[2] = qmul(c, qdot(a11, a31, a12, a32, a13, a33));
                    f[3] = qmul(c, qdot(a21, a21, a22, a22, a23, a23));
                    f[4] = qmul(c, qdot(a21, a31, a22, a32, a23, a33));
                    f[5] = qmul(c, qdot(a31, a31, a32, a32, a33, a33));
                end
            end
            MODE_SURFACE:
            begin
                e    = qdot(j11, j11, j21, j21, j31, j31);
                g    = qdot(j12, j12, j22, j22, j32, j32);
                fm   = qdot(j11, j12, j21, j22, j31, j32);
                area = qcross(e, g, fm, fm);
                if (area <= 0)
                    r.sing = 1'b1;
                else
                begin
                    alpha = qdiv(wc, qroot(area));
                    f[0] = qmul(alpha, g);
                    f[1] = sat32(-qmul(alpha, fm));
                    f[2] = qmul(alpha, e);
                end
            end
            default:
                r.sing = 1'b1;
        endcase
        foreach (r.f[k])
            r.f[k] = r.sing ? '0 : q_t'(f[k]);
        return r;
    endfunction

    // ---------------- driving ----------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    task automatic send_point(input point_t p);
        int gap;
        bit hs;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, p.weight, p.jac[8], p.jac[7], p.jac[6], p.jac[5], p.jac[4],
                     p.jac[3], p.jac[2], p.jac[1], p.jac[0]};
        do
        begin
            @(negedge clk);
            hs = s_tready;
            if (hs)
                factor_q.push_back(predict_factor(p));
            @(posedge clk);
        end
        while (!hs);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (factor_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        bit hs;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            cur_mode = val[1:0];
        else
            cur_coeff = q_t'(val);
        @(posedge clk);
    endtask

    // result side: random stall (none in bursts), then one transaction, checked field by field
    initial
    begin : result_check
        int      stall;
        bit      hs;
        factor_t got;
        factor_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs = m_tvalid;
                foreach (got.f[k])
                    got.f[k] = m_tdata[32*k +: 32];
                got.sing = m_tuser[0];
                @(posedge clk);
            end
            while (!hs);
            if (factor_q.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                want = factor_q.pop_front();
                foreach (got.f[k])
                    if (got.f[k] !== want.f[k])
                        report_mismatch($sformatf("factor %0d", k), got.f[k], want.f[k]);
                if (got.sing !== want.sing)
                    report_mismatch("singular", got.sing, want.sing);
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic q_t rand_q();
        case ($urandom_range(0, 9))
            0:       return q_t'($urandom);
            1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            2:       return '0;
            3:       return q_t'($urandom_range(0, 2 * 65536 * 64) - 65536 * 64);
            default: return q_t'($urandom_range(0, 2 * 65536 * 4) - 65536 * 4);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        foreach (p.jac[k])
            p.jac[k] = rand_q();
        case ($urandom_range(0, 5))
            0:       p.weight = 31'($urandom);
            1:       p.weight = $urandom_range(0, 1) ? '1 : '0;
            default: p.weight = 31'($urandom_range(0, 65536 * 4));
        endcase
        return p;
    endfunction

    function automatic point_t make_point(input longint j [9], input longint w);
        point_t p;
        foreach (p.jac[k])
            p.jac[k] = q_t'(j[k]);
        p.weight = 31'(w);
        return p;
    endfunction

    localparam longint ONE = 65536;

    task automatic test_planar();
        write_reg(CFG_MODE, {30'd0, MODE_PLANAR});
        send_point(make_point('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0}, ONE));
        send_point(make_point('{2*ONE, ONE, 0, -ONE, 3*ONE, 0, 0, 0, 0}, ONE / 2));
        send_point(make_point('{ONE, 2*ONE, 0, ONE, 2*ONE, 0, 0, 0, 0}, ONE));  // zero det
        send_point(make_point('{SAT_HI, SAT_LO, SAT_HI, SAT_LO, SAT_HI, SAT_LO, 0, 0, 0},
                              64'h7fffffff));
        send_point(make_point('{SAT_LO, 0, 0, 0, SAT_LO, 0, 0, 0, 0}, 0));
    endtask

    task automatic test_volume();
        write_reg(CFG_MODE, {30'd0, MODE_VOLUME});
        send_point(make_point('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, ONE));
        send_point(make_point('{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE}, 3 * ONE));
        send_point(make_point('{ONE, 0, 0, ONE, 0, 0, 0, 0, ONE}, ONE));  // zero det
        send_point(make_point('{SAT_HI, SAT_HI, SAT_LO, SAT_LO, SAT_HI, SAT_LO,
                                SAT_HI, SAT_LO, SAT_HI}, 64'h7fffffff));
    endtask

    task automatic test_surface();
        write_reg(CFG_MODE, {30'd0, MODE_SURFACE});
        send_point(make_point('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0}, ONE));
        send_point(make_point('{ONE, 0, ONE, 0, 2*ONE, ONE, 0, 0, 0}, ONE));
        send_point(make_point('{ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0}, ONE));  // flat
        send_point(make_point('{SAT_HI, 0, 0, 0, SAT_HI, 0, 0, 0, 0}, ONE));
    endtask

    task automatic test_undefined_mode();
        write_reg(CFG_MODE, {30'h3fffffff, MODE_UNDEF});
        send_point(make_point('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, ONE));
        send_point(rand_point());
    endtask

    task automatic test_coeff_extremes();
        longint cset [4] = '{SAT_HI, SAT_LO, 0, -ONE};
        foreach (cset[i])
        begin
            write_reg(CFG_COEFF, 32'(cset[i]));
            write_reg(CFG_MODE, {30'd0, 2'($urandom_range(0, 2))});
            send_point(make_point('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, ONE));
            send_point(rand_point());
        end
        write_reg(CFG_COEFF, 32'(COEFF_ONE));
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_MODE, {30'($urandom), 2'($urandom_range(0, 9) == 0 ? 3 : ph % 3)});
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_COEFF, $urandom);
                1:       write_reg(CFG_COEFF, 32'(COEFF_ONE));
                default: write_reg(CFG_COEFF, 32'($urandom_range(0, 8 * ONE) - 4 * ONE));
            endcase
            burst = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < 125; i++)
            begin
                send_point(rand_point());
                if (ph == 4 && i == 60)
                    test_drain_pause();
            end
            burst = 1'b0;
        end
    endtask

    // hold the sender until the pipeline is empty, then carry on
    task automatic test_drain_pause();
        wait_drained();
        repeat ($urandom_range(1, 20)) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cycles    = 0;
        err_count = 0;
        burst     = 1'b0;
        cur_mode  = MODE_PLANAR;
        cur_coeff = COEFF_ONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_planar();
        test_volume();
        test_surface();
        test_undefined_mode();
        test_coeff_extremes();
        test_random();

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (err_count == 0)
            $display("[diffusion_geometric_factor] OK");
        else
            $display("[diffusion_geometric_factor] ERROR");
        $finish;
    end

endmodule
